@@ design/port_listener_table_defines.svh @@
// Assertion macros for the port listener table.
// Used by port_listener_table.sv; expects clk and rst_n in scope.
`ifndef PORT_LISTENER_TABLE_DEFINES_SVH
`define PORT_LISTENER_TABLE_DEFINES_SVH

// same-cycle implication, off during reset
`define PLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define PLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/plt_pkg.sv @@
// Shared types, constants and helpers for the port listener table.
// No dependencies; used by plt_store and port_listener_table.
`default_nettype none

package plt_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int RES_CAP   = 8;

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDXC_W = $clog2(NUM_SLOTS + 1);
    localparam int CNT_W  = (RES_CAP > 1) ? $clog2(RES_CAP) : 1;

    localparam int OP_W   = 2;
    localparam int PORT_W = 16;
    localparam int HID_W  = 8;
    localparam int LEN_W  = 16;
    localparam int SLOT_W = 3;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [HID_W-1:0]  handler;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } wr_req_t;

    // slot field is the low bits of the table index
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] wide;
        wide = {{SLOT_W{1'b0}}, idx};
        return wide[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/plt_store.sv @@
// Slot store: one-read one-write synchronous memory plus per-entry valid bits.
// Depends on plt_pkg. Entries never written read as zero (free).
`default_nettype none

module plt_store
    import plt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_entry,
    input  wire wr_req_t          wr
);

    entry_t                 mem [NUM_SLOTS];
    entry_t                 rd_data_reg;
    logic                   rd_valid_reg;
    logic [NUM_SLOTS-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ design/port_listener_table.sv @@
// Port listener table top level: command sequencer around the slot store.
// Depends on plt_pkg, plt_store and port_listener_table_defines.svh.
//
// Usage:
//   Command side: drive opcode, port, handler_id and payload_length with
//   start high; the word is taken on the edge where start is high and busy
//   is low. busy stays high until the command's last result is issued.
//   Result side: each result word sits on ok/slot/handler_out/length_out/last
//   for exactly one cycle with result_strobe high. There is no backpressure;
//   the receiver must take every strobed word.
//   Add and remove give one result; lookup gives one result per matching
//   slot that has a handler (in slot order, last marks the final one), or a
//   single result with ok low when nothing matches.
// Scan:
//   The scan reads one slot per cycle from the store (registered read);
//   add and remove stop at the first hit.
//   Lookup holds one found result back so last can be set on the final one,
//   which costs a flush state at the end of the scan.
//   Writes land at the edge that issues the result, before the next command
//   can read, so no forwarding is needed.
// Reset:
//   rst_n clears the valid bits, so every slot reads free at once; no
//   clearing pass is needed and a command can be taken right after reset.
`default_nettype none
`include "port_listener_table_defines.svh"

module port_listener_table
    import plt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [PORT_W-1:0] port,
    input  wire logic [HID_W-1:0]  handler_id,
    input  wire logic [LEN_W-1:0]  payload_length,
    output logic                   result_strobe,
    output logic                   ok,
    output logic [SLOT_W-1:0]      slot,
    output logic [HID_W-1:0]       handler_out,
    output logic [LEN_W-1:0]       length_out,
    output logic                   last
);

    // sequencer state
    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [HID_W-1:0]    hid_reg, hid_next;
    logic [LEN_W-1:0]    len_reg, len_next;

    // read issue pointer and check stage
    logic [IDXC_W-1:0]   idx_reg, idx_next;
    logic                chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;

    // lookup result held back one match
    logic                pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [HID_W-1:0]    pend_hid_reg, pend_hid_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // result word
    logic                strobe_reg, strobe_next;
    logic                ok_reg, ok_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [HID_W-1:0]    hout_reg, hout_next;
    logic [LEN_W-1:0]    lout_reg, lout_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                rd_en;
    entry_t              rd_entry;
    wr_req_t             wr_req;
    logic                chk_last;
    logic                hit_add, hit_rem, hit_lkp;
    logic [CNT_W-1:0]    emitted_next;
    logic                cap_hit;

    plt_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (idx_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .wr       (wr_req)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign rd_en  = (state_reg == ST_SCAN) && (idx_reg != IDXC_W'(NUM_SLOTS));

    assign chk_last = (chk_idx_reg == IDX_W'(NUM_SLOTS - 1));
    assign hit_add  = (port_reg != '0) &&
                      ((rd_entry.port == port_reg) || (rd_entry.port == '0));
    assign hit_rem  = (rd_entry.port == port_reg);
    assign hit_lkp  = (rd_entry.port == port_reg) && (rd_entry.handler != '0);

    // results already sent once the held one goes out; held match is the next
    assign emitted_next = cnt_reg + CNT_W'(pend_vld_reg);
    assign cap_hit      = (emitted_next == CNT_W'(RES_CAP - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg)
                begin
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            if (hit_add || chk_last)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (hit_rem || chk_last)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if ((hit_lkp && cap_hit) || chk_last)
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        default:
                        begin
                            if (chk_last)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        op_next       = op_reg;
        port_next     = port_reg;
        hid_next      = hid_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        pend_vld_next = pend_vld_reg;
        pend_idx_next = pend_idx_reg;
        pend_hid_next = pend_hid_reg;
        cnt_next      = cnt_reg;
        wr_req        = '0;
        strobe_next   = 1'b0;
        ok_next       = 1'b0;
        slot_next     = '0;
        hout_next     = '0;
        lout_next     = '0;
        last_next     = 1'b0;

        chk_vld_next = rd_en && (state_next == ST_SCAN);
        chk_idx_next = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next       = opcode;
                    port_next     = port;
                    hid_next      = handler_id;
                    len_next      = payload_length;
                    idx_next      = '0;
                    pend_vld_next = 1'b0;
                    cnt_next      = '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    idx_next = idx_reg + IDXC_W'(1);
                end
                if (chk_vld_reg)
                begin
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            if (hit_add)
                            begin
                                wr_req.en           = 1'b1;
                                wr_req.addr         = chk_idx_reg;
                                wr_req.data.port    = port_reg;
                                wr_req.data.handler = hid_reg;
                                ok_next             = 1'b1;
                                slot_next           = slot_of(chk_idx_reg);
                            end
                            strobe_next = hit_add || chk_last;
                            last_next   = 1'b1;
                        end
                        OP_REMOVE:
                        begin
                            if (hit_rem)
                            begin
                                wr_req.en   = 1'b1;
                                wr_req.addr = chk_idx_reg;
                                ok_next     = 1'b1;
                                slot_next   = slot_of(chk_idx_reg);
                            end
                            strobe_next = hit_rem || chk_last;
                            last_next   = 1'b1;
                        end
                        OP_LOOKUP:
                        begin
                            if (hit_lkp)
                            begin
                                // a new match releases the held one, not last
                                if (pend_vld_reg)
                                begin
                                    strobe_next = 1'b1;
                                    ok_next     = 1'b1;
                                    slot_next   = slot_of(pend_idx_reg);
                                    hout_next   = pend_hid_reg;
                                    lout_next   = len_reg;
                                end
                                cnt_next      = emitted_next;
                                pend_vld_next = 1'b1;
                                pend_idx_next = chk_idx_reg;
                                pend_hid_next = rd_entry.handler;
                            end
                        end
                        default:
                        begin
                            strobe_next = chk_last;
                            last_next   = 1'b1;
                        end
                    endcase
                end
            end
            ST_FLUSH:
            begin
                strobe_next   = 1'b1;
                last_next     = 1'b1;
                pend_vld_next = 1'b0;
                if (pend_vld_reg)
                begin
                    ok_next   = 1'b1;
                    slot_next = slot_of(pend_idx_reg);
                    hout_next = pend_hid_reg;
                    lout_next = len_reg;
                end
            end
            default:
            begin
                pend_vld_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            chk_vld_reg  <= chk_vld_next;
            pend_vld_reg <= pend_vld_next;
            cnt_reg      <= cnt_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        port_reg     <= port_next;
        hid_reg      <= hid_next;
        len_reg      <= len_next;
        chk_idx_reg  <= chk_idx_next;
        pend_idx_reg <= pend_idx_next;
        pend_hid_reg <= pend_hid_next;
        ok_reg       <= ok_next;
        slot_reg     <= slot_next;
        hout_reg     <= hout_next;
        lout_reg     <= lout_next;
        last_reg     <= last_next;
    end

    assign result_strobe = strobe_reg;
    assign ok            = ok_reg;
    assign slot          = slot_reg;
    assign handler_out   = hout_reg;
    assign length_out    = lout_reg;
    assign last          = last_reg;

    `PLT_ASSERT_NEXT(a_accept_starts_scan, accept, (state_reg == ST_SCAN) && (idx_reg == '0), "accepted command did not start a scan from slot zero")
    `PLT_ASSERT_NOW(a_write_only_add_remove, wr_req.en, (state_reg == ST_SCAN) && ((op_reg == OP_ADD) || (op_reg == OP_REMOVE)), "table write outside an add or remove scan")
    `PLT_ASSERT_NOW(a_nonlast_is_lookup, strobe_reg && !last_reg, ok_reg && (op_reg == OP_LOOKUP), "non-final result from a command other than a lookup hit")
    `PLT_ASSERT_NOW(a_last_frees_block, strobe_reg && last_reg, state_reg == ST_IDLE, "final result issued while still busy")
    `PLT_ASSERT_NOW(a_pending_only_lookup, pend_vld_reg && busy, op_reg == OP_LOOKUP, "held result outside a lookup")

endmodule

`default_nettype wire

@@ test/port_listener_table_check.sv @@
`timescale 1ns / 1ps
// Checker for port_listener_table: keeps its own listener table, predicts the
// result words of every accepted command word and compares them as they are strobed.
// Depends on plt_pkg.

module port_listener_table_check
    import plt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [OP_W-1:0]   opcode,
    input  wire logic [PORT_W-1:0] port,
    input  wire logic [HID_W-1:0]  handler_id,
    input  wire logic [LEN_W-1:0]  payload_length,
    input  wire logic              result_strobe,
    input  wire logic              ok,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [HID_W-1:0]  handler_out,
    input  wire logic [LEN_W-1:0]  length_out,
    input  wire logic              last,
    output int                     mismatches,
    output int                     pending,
    output int                     words_checked,
    output int                     dispatches
);

    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [HID_W-1:0]  handler;
        logic [LEN_W-1:0]  length;
        logic              last;
    } result_word_t;

    logic [PORT_W-1:0] listen_port    [NUM_SLOTS];
    logic [HID_W-1:0]  listen_handler [NUM_SLOTS];
    result_word_t      due_words[$];

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch: %s got %0h want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic void push_due(logic okv, int idx, logic [HID_W-1:0] hid,
                                     logic [LEN_W-1:0] len, logic lst);
        result_word_t w;
        w.ok      = okv;
        w.slot    = SLOT_W'(idx);
        w.handler = hid;
        w.length  = len;
        w.last    = lst;
        due_words.push_back(w);
    endfunction

    // table update and expected words for one command
    function automatic void dispatch_command(logic [OP_W-1:0] op, logic [PORT_W-1:0] p,
                                             logic [HID_W-1:0] hid, logic [LEN_W-1:0] len);
        int hit;
        int n;
        int k;
        hit = -1;
        n = 0;
        k = 0;
        case (op)
            OP_ADD: begin
                // first slot that already holds the port or is free
                if (p != '0)
                    for (int i = 0; i < NUM_SLOTS && hit < 0; i++)
                        if (listen_port[i] == p || listen_port[i] == '0)
                            hit = i;
                if (hit >= 0) begin
                    listen_port[hit]    = p;
                    listen_handler[hit] = hid;
                    push_due(1'b1, hit, '0, '0, 1'b1);
                end
                else
                    push_due(1'b0, 0, '0, '0, 1'b1);
            end
            OP_REMOVE: begin
                // port zero matches a free slot: clearing it changes nothing
                for (int i = 0; i < NUM_SLOTS && hit < 0; i++)
                    if (listen_port[i] == p)
                        hit = i;
                if (hit >= 0) begin
                    listen_port[hit]    = '0;
                    listen_handler[hit] = '0;
                    push_due(1'b1, hit, '0, '0, 1'b1);
                end
                else
                    push_due(1'b0, 0, '0, '0, 1'b1);
            end
            OP_LOOKUP: begin
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (listen_port[i] == p && listen_handler[i] != '0 && n < RES_CAP)
                        n++;
                for (int i = 0; i < NUM_SLOTS; i++)
                    if (listen_port[i] == p && listen_handler[i] != '0 && k < n) begin
                        k++;
                        push_due(1'b1, i, listen_handler[i], len, k == n);
                    end
                if (n == 0)
                    push_due(1'b0, 0, '0, '0, 1'b1);
                dispatches += n;
            end
            default: push_due(1'b0, 0, '0, '0, 1'b1);
        endcase
    endfunction

    task automatic check_word();
        result_word_t got;
        result_word_t want;
        got = {ok, slot, handler_out, length_out, last};
        words_checked++;
        if (due_words.size() == 0)
            report_mismatch("result word with nothing due", int'(got), 0);
        else begin
            want = due_words.pop_front();
            if (got.ok != want.ok)
                report_mismatch("ok", got.ok, want.ok);
            if (got.slot != want.slot)
                report_mismatch("slot", got.slot, want.slot);
            if (got.handler != want.handler)
                report_mismatch("handler_out", got.handler, want.handler);
            if (got.length != want.length)
                report_mismatch("length_out", got.length, want.length);
            if (got.last != want.last)
                report_mismatch("last", got.last, want.last);
        end
    endtask

    // result first, then the new command: a word leaving and a command
    // arriving at the same edge keep their order in the queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                listen_port[i]    = '0;
                listen_handler[i] = '0;
            end
            due_words.delete();
        end
        else
        begin
            if (result_strobe)
                check_word();
            if (start && !busy)
                dispatch_command(opcode, port, handler_id, payload_length);
        end
        pending = due_words.size();
    end

endmodule

@@ test/port_listener_table_test.sv @@
`timescale 1ns / 1ps
// Top of the port_listener_table testbench: clock, reset and command stimulus.
// Depends on plt_pkg, the block and port_listener_table_check.

module port_listener_table_test;
    import plt_pkg::*;

    // opcode the block leaves unused; it must answer with a bare last word
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = NUM_SLOTS + 6;
    localparam int POOL_SIZE   = 3;

    logic              clk;
    logic              rst_n          = 1'b0;
    logic              start          = 1'b0;
    logic [OP_W-1:0]   opcode         = OP_ADD;
    logic [PORT_W-1:0] port           = '0;
    logic [HID_W-1:0]  handler_id     = '0;
    logic [LEN_W-1:0]  payload_length = '0;

    wire logic              busy;
    wire logic              result_strobe;
    wire logic              ok;
    wire logic [SLOT_W-1:0] slot;
    wire logic [HID_W-1:0]  handler_out;
    wire logic [LEN_W-1:0]  length_out;
    wire logic              last;

    int mismatches;
    int pending;
    int words_checked;
    int dispatches;

    int cycles     = 0;
    int words_sent = 0;
    int idle_pct   = 0;

    // small set of ports per phase so adds, removes and lookups collide
    logic [PORT_W-1:0] busy_ports [POOL_SIZE];

    port_listener_table dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .port           (port),
        .handler_id     (handler_id),
        .payload_length (payload_length),
        .result_strobe  (result_strobe),
        .ok             (ok),
        .slot           (slot),
        .handler_out    (handler_out),
        .length_out     (length_out),
        .last           (last)
    );

    port_listener_table_check checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .port           (port),
        .handler_id     (handler_id),
        .payload_length (payload_length),
        .result_strobe  (result_strobe),
        .ok             (ok),
        .slot           (slot),
        .handler_out    (handler_out),
        .length_out     (length_out),
        .last           (last),
        .mismatches     (mismatches),
        .pending        (pending),
        .words_checked  (words_checked),
        .dispatches     (dispatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL port_listener_table");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge that took the word.
    // start is left high so back-to-back words go out with no idle gap.
    task automatic send_word(logic [OP_W-1:0] op, logic [PORT_W-1:0] p,
                             logic [HID_W-1:0] hid, logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start          <= 1'b1;
        opcode         <= op;
        port           <= p;
        handler_id     <= hid;
        payload_length <= len;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
    endtask

    // hold off until every predicted word has been seen
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // mostly a real handler, now and then the null one
    function automatic logic [HID_W-1:0] pick_handler();
        return ($urandom_range(0, 7) == 0) ? '0 : HID_W'($urandom_range(1, 255));
    endfunction

    // From an empty table: fill slots 0..6 with fillers, put the port in slot 7,
    // then swap each filler for the port from the back, since a free slot ahead
    // of a match is claimed. Ends with all eight slots on one port, a lookup
    // that dispatches up to eight handlers, and a cleanup back to empty.
    task automatic ladder();
        logic [PORT_W-1:0] p;
        p = PORT_W'($urandom_range(16, 65535));
        for (int k = 0; k < NUM_SLOTS - 1; k++)
            send_word(OP_ADD, p ^ PORT_W'(k + 1), pick_handler(), LEN_W'($urandom));
        send_word(OP_ADD, p, pick_handler(), LEN_W'($urandom));
        for (int k = NUM_SLOTS - 2; k >= 0; k--)
        begin
            send_word(OP_REMOVE, p ^ PORT_W'(k + 1), HID_W'($urandom), LEN_W'($urandom));
            send_word(OP_ADD, p, pick_handler(), LEN_W'($urandom));
        end
        send_word(OP_LOOKUP, p, HID_W'($urandom), LEN_W'($urandom));
        repeat (NUM_SLOTS)
            send_word(OP_REMOVE, p, HID_W'($urandom), LEN_W'($urandom));
    endtask

    // Random traffic on the pool ports. Stray ports are only added as
    // add/lookup/remove triples, so the table holds pool ports alone afterwards.
    task automatic churn(int n);
        int pick;
        logic [PORT_W-1:0] pp;
        logic [PORT_W-1:0] stray;
        for (int i = 0; i < n; i++)
        begin
            pick  = $urandom_range(0, 99);
            pp    = busy_ports[$urandom_range(0, POOL_SIZE - 1)];
            stray = PORT_W'($urandom);
            if (pick < 40)
                send_word(OP_ADD, pp, pick_handler(), LEN_W'($urandom));
            else if (pick < 60)
                send_word(OP_REMOVE, pp, HID_W'($urandom), LEN_W'($urandom));
            else if (pick < 85)
                send_word(OP_LOOKUP, pp, HID_W'($urandom), LEN_W'($urandom));
            else if (pick < 92)
            begin
                send_word(OP_ADD, stray, pick_handler(), LEN_W'($urandom));
                send_word(OP_LOOKUP, stray, HID_W'($urandom), LEN_W'($urandom));
                send_word(OP_REMOVE, stray, HID_W'($urandom), LEN_W'($urandom));
            end
            else
                case ($urandom_range(0, 3))
                    0: send_word(OP_UNUSED, stray, HID_W'($urandom), LEN_W'($urandom));
                    1: send_word(OP_LOOKUP, stray, HID_W'($urandom), LEN_W'($urandom));
                    2: send_word(OP_REMOVE, stray, HID_W'($urandom), LEN_W'($urandom));
                    default: send_word(OP_REMOVE, '0, HID_W'($urandom), LEN_W'($urandom));
                endcase
        end
    endtask

    initial
    begin
        // sender idle percentage per random phase
        int idle_mix [4];
        idle_mix = '{0, 80, 0, 18};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, failures, update in place, duplicate port,
        // null handler, full table, unused opcode
        send_word(OP_LOOKUP, 16'h0001, 8'hFF, 16'hFFFF);   // nothing matches
        send_word(OP_ADD,    16'h0000, 8'h05, 16'h1234);   // port zero refused
        send_word(OP_REMOVE, 16'h0000, 8'h00, 16'h0000);   // no-op, free slot 0
        send_word(OP_REMOVE, 16'h1234, 8'h00, 16'h0000);   // absent port
        send_word(OP_ADD,    16'hFFFF, 8'hFF, 16'h0000);   // slot 0
        send_word(OP_ADD,    16'h0001, 8'h01, 16'hFFFF);   // slot 1
        send_word(OP_ADD,    16'hFFFF, 8'h80, 16'h0000);   // update slot 0
        send_word(OP_LOOKUP, 16'hFFFF, 8'h00, 16'hFFFF);
        send_word(OP_ADD,    16'h0100, 8'h00, 16'h0000);   // slot 2, null handler
        send_word(OP_LOOKUP, 16'h0100, 8'h00, 16'hA5A5);   // match but no handler
        send_word(OP_REMOVE, 16'hFFFF, 8'h00, 16'h0000);   // frees slot 0
        send_word(OP_ADD,    16'h0001, 8'h7F, 16'h0000);   // free slot ahead of match
        send_word(OP_LOOKUP, 16'h0001, 8'h00, 16'h0000);   // two dispatches
        send_word(OP_UNUSED, 16'hFFFF, 8'hFF, 16'hFFFF);
        for (int k = 0; k < 5; k++)
            send_word(OP_ADD, 16'h2000 + PORT_W'(k), HID_W'(8'h10 + k), 16'h0000);
        send_word(OP_ADD,    16'h3000, 8'h33, 16'h0000);   // full table
        send_word(OP_REMOVE, 16'h0000, 8'h00, 16'h0000);   // no free slot
        send_word(OP_ADD,    16'h2002, 8'hAA, 16'h0000);   // update while full
        send_word(OP_LOOKUP, 16'h2002, 8'h00, 16'h5555);
        send_word(OP_REMOVE, 16'h0100, 8'h00, 16'h0000);
        send_word(OP_LOOKUP, 16'h0000, 8'h00, 16'hFFFF);   // free slots never dispatch

        // empty the table again so each phase starts from a known state
        send_word(OP_REMOVE, 16'h0001, 8'h00, 16'h0000);
        send_word(OP_REMOVE, 16'h0001, 8'h00, 16'h0000);
        for (int k = 0; k < 5; k++)
            send_word(OP_REMOVE, 16'h2000 + PORT_W'(k), 8'h00, 16'h0000);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = idle_mix[phase];
            for (int k = 0; k < POOL_SIZE; k++)
                busy_ports[k] = PORT_W'($urandom_range(1, 65535));
            ladder();
            churn(25);
            // at most eight copies of any pool port can be resident
            for (int k = 0; k < POOL_SIZE; k++)
                repeat (NUM_SLOTS)
                    send_word(OP_REMOVE, busy_ports[k], HID_W'($urandom), LEN_W'($urandom));
            drain();
        end

        repeat (SETTLE) @(posedge clk);

        $display("covered %0d command words in %0d cycles, %0d result words checked",
                 words_sent, cycles, words_checked);
        $display("%0d handler dispatches, including full-table duplicate ladders",
                 dispatches);
        if (mismatches == 0 && pending == 0)
            $display("PASS port_listener_table");
        else
            $display("FAIL port_listener_table");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/plt_pkg.sv
design/plt_store.sv
design/port_listener_table.sv
test/port_listener_table_check.sv
test/port_listener_table_test.sv
